// File: hdl/acs_pkg.sv
// Shared types, constants and per-channel record layout for the audio channel statistics block.
package acs_pkg;

	localparam int MAX_CHANNELS = 8;
	localparam int SAMPLE_BITS  = 24;
	localparam int CH_W         = 3;
	localparam int CNT_W        = 32;
	localparam int SUM_W        = 56;
	localparam int SQ_W         = 64;
	localparam int THR_W        = 24;
	localparam int CC_W         = 4;

	typedef enum logic [1:0] {
		REG_CHANNEL_COUNT = 2'd0,
		REG_SILENCE_THR   = 2'd1,
		REG_CLIP_THR      = 2'd2,
		REG_UNUSED        = 2'd3
	} reg_index_t;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_FINITE  = 2'd0,
		KIND_NAN     = 2'd1,
		KIND_POS_INF = 2'd2,
		KIND_NEG_INF = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		SIGN_NONE = 2'd0,
		SIGN_POS  = 2'd1,
		SIGN_NEG  = 2'd2,
		SIGN_RSVD = 2'd3
	} sign_t;

	typedef struct packed {
		logic [CNT_W-1:0]              finite_cnt;
		logic [CNT_W-1:0]              nan_cnt;
		logic [CNT_W-1:0]              pos_inf_cnt;
		logic [CNT_W-1:0]              neg_inf_cnt;
		logic signed [SAMPLE_BITS-1:0] min_val;
		logic signed [SAMPLE_BITS-1:0] max_val;
		logic signed [SUM_W-1:0]       sum;
		logic [SQ_W-1:0]               sum_sq;
		logic [CNT_W-1:0]              clip_cnt;
		logic [CNT_W-1:0]              silence_cnt;
		logic [CNT_W-1:0]              silence_run;
		logic [CNT_W-1:0]              longest_run;
		logic [CNT_W-1:0]              cross_cnt;
		sign_t                         prev_sign;
	} stats_t;

	typedef struct packed {
		logic [THR_W-1:0] silence_thr;
		logic [THR_W-1:0] clip_thr;
	} thr_t;

	localparam int STATS_W = $bits(stats_t);

	function automatic stats_t empty_stats();
		stats_t r;
		r             = '0;
		r.min_val     = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		r.max_val     = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		r.prev_sign   = SIGN_NONE;
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (&v) ? v : v + CNT_W'(1);
	endfunction

endpackage

// File: hdl/acs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module acs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/acs_update.sv
// Combinational read-modify step: folds one sample into a channel record.
module acs_update (
	input  acs_pkg::stats_t                      cur,
	input  acs_pkg::kind_t                       kind,
	input  logic signed [acs_pkg::SAMPLE_BITS-1:0] sample,
	input  logic [acs_pkg::SAMPLE_BITS-1:0]      mag,
	input  logic [2*acs_pkg::SAMPLE_BITS-1:0]    sq,
	input  acs_pkg::thr_t                        thr,
	output acs_pkg::stats_t                      nxt
);

	logic signed [acs_pkg::SUM_W:0] sum_ext;
	logic [acs_pkg::SQ_W:0]         sq_ext;
	logic                           silent;
	logic [acs_pkg::CNT_W-1:0]      run_nxt;

	always_comb begin
		sum_ext = {cur.sum[acs_pkg::SUM_W-1], cur.sum}
			+ (acs_pkg::SUM_W+1)'(sample);
		sq_ext  = {1'b0, cur.sum_sq} + (acs_pkg::SQ_W+1)'(sq);
		silent  = mag <= thr.silence_thr;
		run_nxt = silent ? acs_pkg::sat_inc(cur.silence_run) : '0;
	end

	always_comb begin
		nxt = cur;
		unique case (kind)
			acs_pkg::KIND_NAN:     nxt.nan_cnt     = acs_pkg::sat_inc(cur.nan_cnt);
			acs_pkg::KIND_POS_INF: nxt.pos_inf_cnt = acs_pkg::sat_inc(cur.pos_inf_cnt);
			acs_pkg::KIND_NEG_INF: nxt.neg_inf_cnt = acs_pkg::sat_inc(cur.neg_inf_cnt);
			acs_pkg::KIND_FINITE: begin
				nxt.finite_cnt = acs_pkg::sat_inc(cur.finite_cnt);
				// clamp on overflow of the 56-bit signed sum
				if (sum_ext[acs_pkg::SUM_W] != sum_ext[acs_pkg::SUM_W-1]) begin
					nxt.sum = sum_ext[acs_pkg::SUM_W]
						? {1'b1, {(acs_pkg::SUM_W-1){1'b0}}}
						: {1'b0, {(acs_pkg::SUM_W-1){1'b1}}};
				end else begin
					nxt.sum = sum_ext[acs_pkg::SUM_W-1:0];
				end
				nxt.sum_sq = sq_ext[acs_pkg::SQ_W] ? '1 : sq_ext[acs_pkg::SQ_W-1:0];
				if (sample < cur.min_val) nxt.min_val = sample;
				if (sample > cur.max_val) nxt.max_val = sample;
				if (mag >= thr.clip_thr) nxt.clip_cnt = acs_pkg::sat_inc(cur.clip_cnt);
				if (silent) nxt.silence_cnt = acs_pkg::sat_inc(cur.silence_cnt);
				nxt.silence_run = run_nxt;
				if (run_nxt > cur.longest_run) nxt.longest_run = run_nxt;
				if ((sample > 0 && cur.prev_sign == acs_pkg::SIGN_NEG)
					|| (sample < 0 && cur.prev_sign == acs_pkg::SIGN_POS)) begin
					nxt.cross_cnt = acs_pkg::sat_inc(cur.cross_cnt);
				end
				if (sample > 0) nxt.prev_sign = acs_pkg::SIGN_POS;
				if (sample < 0) nxt.prev_sign = acs_pkg::SIGN_NEG;
			end
			default: nxt = cur;
		endcase
	end

endmodule

// File: hdl/audio_channel_statistics.sv
// Top level: per-channel audio statistics kept in one RAM, updated read-modify-write.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    tdata: channel, sample; tuser: op, sample_kind
//  m_*      out  m_tvalid/m_tready    tdata: twelve statistics fields
//  cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One sample per cycle sustained while m_tready does not stall; a result passes through the
// RAM read at the transaction edge, the square multiply and the record update into the output register.
// Back-to-back samples on one channel are served by forwarding from the update stage
// and from the last write-back, so the RAM port never stalls the stream.
// Reset and clears take effect at once through per-entry valid bits; no clearing pass.
// A stall on m_tready freezes the whole pipeline and drops s_tready.
module audio_channel_statistics (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // [2:0] channel, [26:3] sample, [31:27] zero
	input  logic [2:0]   s_tuser,   // [0] op, [2:1] sample_kind
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] finite_count, [63:32] nan_count, [95:64] pos_inf_count,
	// [127:96] neg_inf_count, [151:128] minimum, [175:152] maximum, [231:176] sum,
	// [295:232] sum_squares, [327:296] clipped_count, [359:328] silence_count,
	// [391:360] max_silence_run, [423:392] zero_crossings
	output logic [423:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [23:0]  cfg_data
);

	localparam int SB = acs_pkg::SAMPLE_BITS;
	localparam int CW = acs_pkg::CH_W;

	typedef struct packed {
		acs_pkg::op_t            op;
		logic [CW-1:0]           ch;
		acs_pkg::kind_t          kind;
		logic signed [SB-1:0]    sample;
	} item_t;

	logic [acs_pkg::CC_W-1:0] chan_count_q;
	acs_pkg::thr_t            thr_q;

	logic                     adv;
	logic                     s_acc;
	logic                     keep;
	logic [acs_pkg::CC_W-1:0] active;

	item_t                    in_item;
	logic                     vld_s1;
	item_t                    item_s1;
	logic                     vld_s2;
	item_t                    item_s2;
	logic [SB-1:0]            mag_s2;
	logic [2*SB-1:0]          sq_s2;
	acs_pkg::stats_t          cur_s2;
	logic [SB-1:0]            mag_s1;

	acs_pkg::stats_t          ram_rdata;
	acs_pkg::stats_t          fwd_rec;
	acs_pkg::stats_t          new_rec;
	logic                     wr_en;

	logic [acs_pkg::MAX_CHANNELS-1:0] ent_vld_q;
	logic                     wb_vld_q;
	logic [CW-1:0]            wb_ch_q;
	acs_pkg::stats_t          wb_rec_q;

	logic                     out_vld_q;
	acs_pkg::stats_t          out_q;
	logic                     cfg_hit;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index != acs_pkg::REG_UNUSED);

	assign adv      = !out_vld_q || m_tready;
	assign s_tready = adv;
	assign s_acc    = s_tvalid && s_tready;

	always_comb begin
		in_item.op     = acs_pkg::op_t'(s_tuser[0]);
		in_item.kind   = acs_pkg::kind_t'(s_tuser[2:1]);
		in_item.ch     = s_tdata[CW-1:0];
		in_item.sample = s_tdata[CW+SB-1:CW];
		active = (chan_count_q > acs_pkg::CC_W'(acs_pkg::MAX_CHANNELS))
			? acs_pkg::CC_W'(acs_pkg::MAX_CHANNELS) : chan_count_q;
		// drop samples on inactive channels right at the input
		keep = (in_item.op == acs_pkg::OP_CLEAR)
			|| (acs_pkg::CC_W'(in_item.ch) < active);
		mag_s1 = item_s1.sample[SB-1] ? SB'(-item_s1.sample) : SB'(item_s1.sample);
	end

	acs_ram #(
		.WIDTH (acs_pkg::STATS_W),
		.DEPTH (acs_pkg::MAX_CHANNELS)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (item_s2.ch),
		.wdata (new_rec),
		.re    (s_acc),
		.raddr (in_item.ch),
		.rdata (ram_rdata)
	);

	// pick the freshest copy of the record for the item entering the update stage
	always_comb begin
		priority if (vld_s2 && item_s2.op == acs_pkg::OP_CLEAR) begin
			fwd_rec = acs_pkg::empty_stats();
		end else if (vld_s2 && item_s2.ch == item_s1.ch) begin
			fwd_rec = new_rec;
		end else if (wb_vld_q && wb_ch_q == item_s1.ch) begin
			fwd_rec = wb_rec_q;
		end else if (ent_vld_q[item_s1.ch]) begin
			fwd_rec = ram_rdata;
		end else begin
			fwd_rec = acs_pkg::empty_stats();
		end
	end

	acs_update u_update (
		.cur    (cur_s2),
		.kind   (item_s2.kind),
		.sample (item_s2.sample),
		.mag    (mag_s2),
		.sq     (sq_s2),
		.thr    (thr_q),
		.nxt    (new_rec)
	);

	assign wr_en = adv && vld_s2 && (item_s2.op == acs_pkg::OP_SAMPLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_count_q <= '0;
			thr_q.silence_thr <= '0;
			thr_q.clip_thr    <= acs_pkg::THR_W'(8388607);
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
			ent_vld_q <= '0;
			wb_vld_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (acs_pkg::reg_index_t'(cfg_index))
					acs_pkg::REG_CHANNEL_COUNT: chan_count_q <= cfg_data[acs_pkg::CC_W-1:0];
					acs_pkg::REG_SILENCE_THR:   thr_q.silence_thr <= cfg_data;
					acs_pkg::REG_CLIP_THR:      thr_q.clip_thr <= cfg_data;
					default: ;
				endcase
			end
			if (adv) begin
				vld_s1 <= s_acc && keep;
				vld_s2 <= vld_s1;
				if (vld_s2 && item_s2.op == acs_pkg::OP_SAMPLE) begin
					out_vld_q <= 1'b1;
				end else begin
					out_vld_q <= 1'b0;
				end
			end
			if (cfg_hit || (adv && vld_s2 && item_s2.op == acs_pkg::OP_CLEAR)) begin
				ent_vld_q <= '0;
				wb_vld_q  <= 1'b0;
			end else if (wr_en) begin
				ent_vld_q[item_s2.ch] <= 1'b1;
				wb_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= in_item;
			item_s2 <= item_s1;
			mag_s2  <= mag_s1;
			sq_s2   <= mag_s1 * mag_s1;
			cur_s2  <= fwd_rec;
			out_q   <= new_rec;
		end
		if (wr_en) begin
			wb_ch_q  <= item_s2.ch;
			wb_rec_q <= new_rec;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_q.cross_cnt, out_q.longest_run, out_q.silence_cnt, out_q.clip_cnt,
		out_q.sum_sq, out_q.sum, out_q.max_val, out_q.min_val,
		out_q.neg_inf_cnt, out_q.pos_inf_cnt, out_q.nan_cnt, out_q.finite_cnt};

	// a clear reaching the update stage empties every entry
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && vld_s2 && item_s2.op == acs_pkg::OP_CLEAR) |=> (ent_vld_q == '0 && !wb_vld_q))
		else $error("clear did not empty the channel store");

	// a write to any register but the unused one empties every entry
	a_cfg_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> (ent_vld_q == '0 && !wb_vld_q))
		else $error("register write did not empty the channel store");

	// once a finite sample is counted, minimum cannot exceed maximum
	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.finite_cnt != '0) |-> (out_q.min_val <= out_q.max_val))
		else $error("minimum above maximum");

	// the write-back copy always names an entry that is marked valid
	a_wb_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wb_vld_q |-> ent_vld_q[wb_ch_q])
		else $error("forwarding copy for an empty entry");

endmodule

// File: sim/testbench.sv
// Self-checking bench for the audio channel statistics block: scoreboard class plus stream drivers.
`timescale 1ns / 100ps

module testbench;

	typedef struct {
		logic [31:0] fin, nan, pinf, ninf;
		logic signed [23:0] mn, mx;
		logic signed [55:0] sum;
		logic [63:0] sq;
		logic [31:0] clip, sil, run, longest, xings;
		acs_pkg::sign_t prev;
	} chan_rec_t;

	class stats_scoreboard;
		chan_rec_t chans[acs_pkg::MAX_CHANNELS];
		logic [3:0] chan_count;
		logic [23:0] silence_thr, clip_thr;
		logic [423:0] pending[$];
		int errors;

		function void empty_all();
			for (int c = 0; c < acs_pkg::MAX_CHANNELS; c++) begin
				chans[c] = '{default: '0, mn: 24'sh7fffff, mx: 24'sh800000,
					prev: acs_pkg::SIGN_NONE};
			end
		endfunction

		function new();
			chan_count = 0;
			silence_thr = 0;
			clip_thr = 24'd8388607;
			errors = 0;
			empty_all();
		endfunction

		function void write_reg(logic [1:0] idx, logic [23:0] val);
			case (acs_pkg::reg_index_t'(idx))
				acs_pkg::REG_CHANNEL_COUNT: chan_count = val[3:0];
				acs_pkg::REG_SILENCE_THR: silence_thr = val;
				acs_pkg::REG_CLIP_THR: clip_thr = val;
				default: return;
			endcase
			empty_all();
		endfunction

		function logic [31:0] inc(logic [31:0] v);
			return (&v) ? v : v + 32'd1;
		endfunction

		// Note one accepted input transaction and queue the result it should cause; clears and dropped samples queue none.
		function void note_input(acs_pkg::op_t op, logic [2:0] ch, acs_pkg::kind_t kind,
			logic signed [23:0] s);
			int active;
			longint mag, ns;
			logic [63:0] sqv;
			logic [64:0] tot;
			chan_rec_t r;
			if (op == acs_pkg::OP_CLEAR) begin
				empty_all();
				return;
			end
			active = chan_count > acs_pkg::MAX_CHANNELS ? acs_pkg::MAX_CHANNELS : chan_count;
			if (ch >= active) return;
			r = chans[ch];
			case (kind)
				acs_pkg::KIND_NAN: r.nan = inc(r.nan);
				acs_pkg::KIND_POS_INF: r.pinf = inc(r.pinf);
				acs_pkg::KIND_NEG_INF: r.ninf = inc(r.ninf);
				default: begin
					mag = s < 0 ? -longint'(s) : longint'(s);
					sqv = mag * mag;
					r.fin = inc(r.fin);
					ns = longint'(r.sum) + longint'(s);
					if (ns > 64'sd36028797018963967) ns = 64'sd36028797018963967;
					if (ns < -64'sd36028797018963968) ns = -64'sd36028797018963968;
					r.sum = ns[55:0];
					tot = {1'b0, r.sq} + {1'b0, sqv};
					r.sq = tot[64] ? '1 : tot[63:0];
					if (s < r.mn) r.mn = s;
					if (s > r.mx) r.mx = s;
					if (mag >= longint'(clip_thr)) r.clip = inc(r.clip);
					if (mag <= longint'(silence_thr)) begin
						r.sil = inc(r.sil);
						r.run = inc(r.run);
						if (r.run > r.longest) r.longest = r.run;
					end else r.run = 0;
					if ((s > 0 && r.prev == acs_pkg::SIGN_NEG)
						|| (s < 0 && r.prev == acs_pkg::SIGN_POS))
						r.xings = inc(r.xings);
					if (s > 0) r.prev = acs_pkg::SIGN_POS;
					if (s < 0) r.prev = acs_pkg::SIGN_NEG;
				end
			endcase
			chans[ch] = r;
			pending.push_back({r.xings, r.longest, r.sil, r.clip, r.sq, r.sum, r.mx, r.mn,
				r.ninf, r.pinf, r.nan, r.fin});
		endfunction

		task check_result(logic [423:0] got);
			logic [423:0] want, mask, g, e;
			if (pending.size() == 0) begin
				report("unexpected result", '0, '0);
				return;
			end
			want = pending.pop_front();
			for (int f = 0; f < 12; f++) begin
				int lo, w;
				lo = field_lo(f);
				w = field_lo(f + 1) - lo;
				mask = (424'd1 << w) - 424'd1;
				g = (got >> lo) & mask;
				e = (want >> lo) & mask;
				if (g != e) report($sformatf("field %0d", f), 128'(g), 128'(e));
			end
		endtask

		function int field_lo(int f);
			int offs[13] = '{0, 32, 64, 96, 128, 152, 176, 232, 296, 328, 360, 392, 424};
			return offs[f];
		endfunction

		task report(string what, logic [127:0] got, logic [127:0] want);
			errors++;
			if (errors <= 40) $display("mismatch: %s got %0h want %0h", what, got, want);
		endtask
	endclass

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0;
	logic [31:0] s_tdata = 0;
	logic [2:0] s_tuser = 0;
	logic [423:0] m_tdata;
	logic cfg_valid = 0, cfg_ready;
	logic [1:0] cfg_index = 0;
	logic [23:0] cfg_data = 0;

	int send_idle = 0, recv_stall = 0;
	logic holding = 0;
	longint cycles = 0;
	stats_scoreboard sb;

	always #4 clk = ~clk;

	audio_channel_statistics i_dut (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: random stalls, held off entirely while holding is set.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
		if (holding) m_tready <= 0;
		else m_tready <= $urandom_range(99) >= recv_stall;
	end

	// Hold the receiver off, for as long as the argument n asks, then let it go again.
	task automatic hold_receiver(int n);
		holding <= 1;
		repeat (n) @(posedge clk);
		holding <= 0;
	endtask

	task automatic send(acs_pkg::op_t op, logic [2:0] ch, acs_pkg::kind_t kind, logic [23:0] s);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {5'd0, s, ch};
		s_tuser <= {kind, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_input(op, ch, kind, s);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [23:0] val);
		drain();
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	function automatic logic [23:0] rand_sample();
		case ($urandom_range(5))
			0: return 24'h7fffff;
			1: return 24'h800000;
			2: return 24'd0;
			3: return 24'($signed($urandom_range(16)) - 8);
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic random_items(int n, int nch);
		for (int i = 0; i < n; i++) begin
			int p;
			acs_pkg::kind_t k;
			p = $urandom_range(99);
			k = p < 80 ? acs_pkg::KIND_FINITE : acs_pkg::kind_t'($urandom_range(3));
			if (p == 99) send(acs_pkg::OP_CLEAR, 3'($urandom), k, 24'($urandom));
			else send(acs_pkg::OP_SAMPLE, p < 92 ? 3'($urandom_range(nch - 1)) : 3'($urandom),
				k, rand_sample());
		end
	endtask

	initial begin
		int phase_idle[4] = '{0, 51, 0, 13};
		int phase_stall[4] = '{0, 0, 51, 13};
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Channel count zero: everything ignored.
		send(acs_pkg::OP_SAMPLE, 3'd0, acs_pkg::KIND_FINITE, 24'd5);
		write_cfg(acs_pkg::REG_CHANNEL_COUNT, 24'd8);
		write_cfg(acs_pkg::REG_SILENCE_THR, 24'd2);
		write_cfg(acs_pkg::REG_CLIP_THR, 24'h7fffff);
		send(acs_pkg::OP_SAMPLE, 3'd0, acs_pkg::KIND_FINITE, 24'h7fffff);
		send(acs_pkg::OP_SAMPLE, 3'd0, acs_pkg::KIND_FINITE, 24'h800000);
		send(acs_pkg::OP_SAMPLE, 3'd0, acs_pkg::KIND_FINITE, 24'd0);
		send(acs_pkg::OP_SAMPLE, 3'd0, acs_pkg::KIND_FINITE, 24'd1);
		send(acs_pkg::OP_SAMPLE, 3'd0, acs_pkg::KIND_FINITE, 24'hfffffe);
		send(acs_pkg::OP_SAMPLE, 3'd0, acs_pkg::KIND_NAN, 24'h123456);
		send(acs_pkg::OP_SAMPLE, 3'd0, acs_pkg::KIND_POS_INF, 24'd0);
		send(acs_pkg::OP_SAMPLE, 3'd0, acs_pkg::KIND_NEG_INF, 24'hffffff);
		send(acs_pkg::OP_SAMPLE, 3'd7, acs_pkg::KIND_FINITE, 24'd1);
		send(acs_pkg::OP_SAMPLE, 3'd7, acs_pkg::KIND_FINITE, 24'd1);
		send(acs_pkg::OP_CLEAR, 3'd7, acs_pkg::KIND_FINITE, 24'd0);
		send(acs_pkg::OP_SAMPLE, 3'd7, acs_pkg::KIND_FINITE, 24'hffffff);
		write_cfg(acs_pkg::REG_UNUSED, 24'hffffff);
		send(acs_pkg::OP_SAMPLE, 3'd7, acs_pkg::KIND_FINITE, 24'd3);
		write_cfg(acs_pkg::REG_CHANNEL_COUNT, 24'd15);
		write_cfg(acs_pkg::REG_CLIP_THR, 24'd0);
		write_cfg(acs_pkg::REG_SILENCE_THR, 24'h800000);
		send(acs_pkg::OP_SAMPLE, 3'd3, acs_pkg::KIND_FINITE, 24'h800000);
		send(acs_pkg::OP_SAMPLE, 3'd3, acs_pkg::KIND_FINITE, 24'h7fffff);
		write_cfg(acs_pkg::REG_CHANNEL_COUNT, 24'd3);
		send(acs_pkg::OP_SAMPLE, 3'd5, acs_pkg::KIND_FINITE, 24'd9);
		send(acs_pkg::OP_SAMPLE, 3'd2, acs_pkg::KIND_FINITE, 24'd9);
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = phase_idle[ph];
			recv_stall = phase_stall[ph];
			write_cfg(acs_pkg::REG_CHANNEL_COUNT,
				ph == 0 ? 24'd8 : 24'(1 + $urandom_range(8)));
			write_cfg(acs_pkg::REG_SILENCE_THR,
				ph == 1 ? 24'h800000 : 24'($urandom_range(4096)));
			write_cfg(acs_pkg::REG_CLIP_THR,
				ph == 2 ? 24'd1 : 24'h700000 + 24'($urandom_range(24'hfffff)));
			if (ph == 0) begin
				@(posedge clk);
				fork
					hold_receiver(300);
				join_none
			end
			random_items(430, sb.chan_count > 8 ? 8 : int'(sb.chan_count));
		end
		drain();
		if (sb.errors == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
